### rtl/heap_chunk_safety_checker_core_assert.svh
// assertion macros used by the checker rtl (hcsc_back)
`ifndef HEAP_CHUNK_SAFETY_CHECKER_CORE_ASSERT_SVH
`define HEAP_CHUNK_SAFETY_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define HCSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcsc assertion failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define HCSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcsc assertion failed");

`endif

### rtl/hcsc_pkg.sv
package hcsc_pkg;

  // chunk table geometry
  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  // queue geometry, powers of two
  localparam int unsigned InQDepth   = 2;
  localparam int unsigned InQPtrW    = $clog2(InQDepth);
  localparam int unsigned InQCntW    = $clog2(InQDepth + 1);
  localparam int unsigned OutQDepth  = 4;
  localparam int unsigned OutQPtrW   = $clog2(OutQDepth);
  localparam int unsigned OutQCntW   = $clog2(OutQDepth + 1);

  // access checks apply only to this operand count
  localparam logic [3:0] CheckedOperands = 4'd2;

  typedef enum logic [2:0] {
    OpSizeNote   = 3'd0,
    OpAllocDone  = 3'd1,
    OpFree       = 3'd2,
    OpReallocRel = 3'd3,
    OpAccess     = 3'd4,
    OpTraceOn    = 3'd5,
    OpTraceOff   = 3'd6,
    OpLeakScan   = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    StOk       = 4'd0,
    StNull     = 4'd1,
    StLive     = 4'd2,
    StDouble   = 4'd3,
    StInvalid  = 4'd4,
    StUnknown  = 4'd5,
    StUaf      = 4'd6,
    StLeak     = 4'd7,
    StNoLeak   = 4'd8,
    StFull     = 4'd9,
    StIgnored  = 4'd10
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] address;
    logic [31:0] byte_count;
    logic [63:0] instr_address;
    logic [3:0]  operand_count;
    logic        in_main_image;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] report_address;
    logic [63:0] report_pc;
    logic        break_request;
    logic        last_of_run;
  } out_item_t;

  // classified transaction handed from front to back
  typedef struct packed {
    in_item_t item;
    logic     access_chk;
    logic     null_addr;
  } cmd_t;

endpackage

### rtl/hcsc_front.sv
module hcsc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  hcsc_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output hcsc_pkg::cmd_t    cmd_o
);

  hcsc_pkg::cmd_t                     mem_q [hcsc_pkg::InQDepth];
  logic [hcsc_pkg::InQPtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [hcsc_pkg::InQCntW-1:0]       cnt_q, cnt_d;
  hcsc_pkg::cmd_t                     cls;
  logic                               wr_en, rd_en;

  // classify the incoming transaction
  always_comb begin
    cls.item       = in_item_i;
    cls.access_chk = (in_item_i.operand_count == hcsc_pkg::CheckedOperands) &&
                     in_item_i.in_main_image;
    cls.null_addr  = (in_item_i.address == 64'd0);
  end

  assign full_o      = (cnt_q == hcsc_pkg::InQCntW'(hcsc_pkg::InQDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  // pointer update
  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + hcsc_pkg::InQCntW'(wr_en) - hcsc_pkg::InQCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

### rtl/hcsc_back.sv
`include "heap_chunk_safety_checker_core_assert.svh"

module hcsc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  hcsc_pkg::cmd_t      cmd_i,
  input  logic                oq_full_i,
  output logic                oq_push_o,
  output hcsc_pkg::out_item_t oq_item_o
);

  localparam int unsigned IdxW = hcsc_pkg::IdxW;
  localparam int unsigned CntW = hcsc_pkg::CntW;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SEmit
  } state_e;

  // chunk table
  logic [63:0] base_mem  [hcsc_pkg::TableDepth];
  logic [31:0] len_mem   [hcsc_pkg::TableDepth];
  logic        freed_mem [hcsc_pkg::TableDepth];

  state_e         state_q, state_d;
  logic [CntW-1:0] issue_q, issue_d, fill_q, fill_d;
  logic           chk_vld_q, chk_vld_d;
  logic [31:0]    pend_q, pend_d;
  logic           trace_q, trace_d, brk_q, brk_d, hold_vld_q, hold_vld_d;

  hcsc_pkg::cmd_t cmd_q, cmd_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic [63:0]    hold_addr_q, hold_addr_d;
  logic [3:0]     res_status_q, res_status_d;
  logic [63:0]    res_addr_q, res_addr_d, res_pc_q, res_pc_d;

  logic [63:0]    rd_base_q;
  logic [31:0]    rd_len_q;
  logic           rd_freed_q;
  logic           rd_en;
  logic [IdxW-1:0] rd_idx, wr_idx;
  logic           add_we, freed_we, freed_wdata;

  hcsc_pkg::op_e  op, opi;
  logic [63:0]    addr, diff;
  logic           match_eq, hit_uaf, leak_hit, stall, done, leak_push;

  assign op       = hcsc_pkg::op_e'(cmd_q.item.operation);
  assign opi      = hcsc_pkg::op_e'(cmd_i.item.operation);
  assign addr     = cmd_q.item.address;
  assign diff     = addr - rd_base_q;
  assign match_eq = (rd_base_q == addr);
  assign hit_uaf  = rd_freed_q && (addr >= rd_base_q) && (diff < {32'd0, rd_len_q});
  assign leak_hit = !rd_freed_q;

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    fill_d       = fill_q;
    chk_vld_d    = chk_vld_q;
    pend_d       = pend_q;
    trace_d      = trace_q;
    brk_d        = brk_q;
    hold_vld_d   = hold_vld_q;
    cmd_d        = cmd_q;
    chk_idx_d    = chk_idx_q;
    hold_addr_d  = hold_addr_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_pc_d     = res_pc_q;
    cmd_ready_o  = 1'b0;
    rd_en        = 1'b0;
    rd_idx       = issue_q[IdxW-1:0];
    wr_idx       = chk_idx_q;
    add_we       = 1'b0;
    freed_we     = 1'b0;
    freed_wdata  = 1'b0;
    done         = 1'b0;
    stall        = 1'b0;
    leak_push    = 1'b0;

    unique case (state_q)
      SIdle: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d        = cmd_i;
          res_status_d = hcsc_pkg::StOk;
          res_addr_d   = cmd_i.item.address;
          res_pc_d     = cmd_i.item.instr_address;
          issue_d      = '0;
          chk_vld_d    = 1'b0;
          hold_vld_d   = 1'b0;
          if (opi <= hcsc_pkg::OpReallocRel && !trace_q) begin
            res_status_d = hcsc_pkg::StIgnored;
            if (opi == hcsc_pkg::OpSizeNote) begin
              res_addr_d = '0;
              res_pc_d   = '0;
            end
            state_d = SEmit;
          end else begin
            unique case (opi)
              hcsc_pkg::OpSizeNote: begin
                pend_d     = cmd_i.item.byte_count;
                res_addr_d = '0;
                res_pc_d   = '0;
                state_d    = SEmit;
              end
              hcsc_pkg::OpAllocDone: begin
                if (cmd_i.null_addr) begin
                  res_status_d = hcsc_pkg::StNull;
                  state_d      = SEmit;
                end else begin
                  state_d = SScan;
                end
              end
              hcsc_pkg::OpFree: state_d = SScan;
              hcsc_pkg::OpReallocRel: begin
                pend_d  = cmd_i.item.byte_count;
                state_d = SScan;
              end
              hcsc_pkg::OpAccess: state_d = cmd_i.access_chk ? SScan : SEmit;
              hcsc_pkg::OpTraceOn: begin
                trace_d    = 1'b1;
                res_addr_d = '0;
                res_pc_d   = '0;
                state_d    = SEmit;
              end
              hcsc_pkg::OpTraceOff: begin
                trace_d    = 1'b0;
                res_addr_d = '0;
                res_pc_d   = '0;
                state_d    = SEmit;
              end
              hcsc_pkg::OpLeakScan: begin
                res_pc_d = '0;
                state_d  = SScan;
              end
              default: state_d = SEmit;
            endcase
          end
        end
      end

      SScan: begin
        // check the entry held in the registered table read
        if (chk_vld_q) begin
          unique case (op)
            hcsc_pkg::OpAllocDone: begin
              if (match_eq) begin
                done = 1'b1;
                if (rd_freed_q) begin
                  freed_we    = 1'b1;
                  freed_wdata = 1'b0;
                end else begin
                  res_status_d = hcsc_pkg::StLive;
                end
              end
            end
            hcsc_pkg::OpFree: begin
              if (match_eq) begin
                done = 1'b1;
                if (rd_freed_q) begin
                  res_status_d = hcsc_pkg::StDouble;
                  brk_d        = 1'b1;
                end else begin
                  freed_we    = 1'b1;
                  freed_wdata = 1'b1;
                end
              end
            end
            hcsc_pkg::OpReallocRel: begin
              if (match_eq) begin
                done        = 1'b1;
                freed_we    = 1'b1;
                freed_wdata = 1'b1;
              end
            end
            hcsc_pkg::OpAccess: begin
              if (hit_uaf) begin
                done         = 1'b1;
                res_status_d = hcsc_pkg::StUaf;
                brk_d        = 1'b1;
              end
            end
            hcsc_pkg::OpLeakScan: begin
              if (leak_hit) begin
                if (hold_vld_q && oq_full_i) begin
                  stall = 1'b1;
                end else begin
                  leak_push   = hold_vld_q;
                  hold_vld_d  = 1'b1;
                  hold_addr_d = rd_base_q;
                end
              end
            end
            default: done = 1'b0;
          endcase
        end

        if (done) begin
          chk_vld_d = 1'b0;
          state_d   = SEmit;
        end else if (!stall) begin
          if (issue_q < fill_q) begin
            // issue the next table read
            rd_en     = 1'b1;
            chk_idx_d = issue_q[IdxW-1:0];
            chk_vld_d = 1'b1;
            issue_d   = issue_q + 1'b1;
          end else begin
            // table exhausted without a terminating match
            chk_vld_d = 1'b0;
            state_d   = SEmit;
            unique case (op)
              hcsc_pkg::OpAllocDone: begin
                if (fill_q < CntW'(hcsc_pkg::TableDepth)) begin
                  add_we = 1'b1;
                  wr_idx = fill_q[IdxW-1:0];
                  fill_d = fill_q + 1'b1;
                end else begin
                  res_status_d = hcsc_pkg::StFull;
                end
              end
              hcsc_pkg::OpFree:       res_status_d = hcsc_pkg::StInvalid;
              hcsc_pkg::OpReallocRel: res_status_d = hcsc_pkg::StUnknown;
              hcsc_pkg::OpLeakScan: begin
                if (hold_vld_d) begin
                  res_status_d = hcsc_pkg::StLeak;
                  res_addr_d   = hold_addr_d;
                end else begin
                  res_status_d = hcsc_pkg::StNoLeak;
                  res_addr_d   = '0;
                end
              end
              default: res_status_d = res_status_q;
            endcase
          end
        end
      end

      SEmit: begin
        if (!oq_full_i) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  // result toward the output queue
  always_comb begin
    oq_push_o = leak_push || (state_q == SEmit && !oq_full_i);
    if (leak_push) begin
      oq_item_o.status         = hcsc_pkg::StLeak;
      oq_item_o.report_address = hold_addr_q;
      oq_item_o.report_pc      = '0;
      oq_item_o.break_request  = brk_q;
      oq_item_o.last_of_run    = 1'b0;
    end else begin
      oq_item_o.status         = res_status_q;
      oq_item_o.report_address = res_addr_q;
      oq_item_o.report_pc      = res_pc_q;
      oq_item_o.break_request  = brk_q;
      oq_item_o.last_of_run    = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      issue_q    <= '0;
      fill_q     <= '0;
      chk_vld_q  <= 1'b0;
      pend_q     <= '0;
      trace_q    <= 1'b0;
      brk_q      <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      fill_q     <= fill_d;
      chk_vld_q  <= chk_vld_d;
      pend_q     <= pend_d;
      trace_q    <= trace_d;
      brk_q      <= brk_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    chk_idx_q    <= chk_idx_d;
    hold_addr_q  <= hold_addr_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_pc_q     <= res_pc_d;
  end

  // chunk table write and registered read
  always_ff @(posedge clk_i) begin
    if (add_we) begin
      base_mem[wr_idx]  <= addr;
      len_mem[wr_idx]   <= pend_q;
      freed_mem[wr_idx] <= 1'b0;
    end else if (freed_we) begin
      freed_mem[wr_idx] <= freed_wdata;
    end
    if (rd_en) begin
      rd_base_q  <= base_mem[rd_idx];
      rd_len_q   <= len_mem[rd_idx];
      rd_freed_q <= freed_mem[rd_idx];
    end
  end

  `HCSC_ASSERT_IMP(a_no_push_when_full, oq_push_o, !oq_full_i)
  `HCSC_ASSERT_IMP(a_fill_in_range, 1'b1, fill_q <= CntW'(hcsc_pkg::TableDepth))
  `HCSC_ASSERT_NXT(a_take_leaves_idle, cmd_valid_i && cmd_ready_o, state_q != SIdle)
  `HCSC_ASSERT_IMP(a_scan_index_bound, state_q == SScan, issue_q <= fill_q)

endmodule

### rtl/hcsc_outq.sv
module hcsc_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hcsc_pkg::out_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output hcsc_pkg::out_item_t item_o
);

  hcsc_pkg::out_item_t             mem_q [hcsc_pkg::OutQDepth];
  logic [hcsc_pkg::OutQPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [hcsc_pkg::OutQCntW-1:0]   cnt_q, cnt_d;
  logic                            wr_en, rd_en;

  assign full_o  = (cnt_q == hcsc_pkg::OutQCntW'(hcsc_pkg::OutQDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  // pointer update
  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + hcsc_pkg::OutQCntW'(wr_en) - hcsc_pkg::OutQCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/heap_chunk_safety_checker_core.sv
// channel   | handshake      | payload
// ----------+----------------+-----------------------------
// events in | push_i, full_o | in_item_i  (hcsc_pkg::in_item_t)
// results   | pop_i, empty_o | out_item_o (hcsc_pkg::out_item_t)
//
// trace, size note, unchecked access and untraced or null-alloc events skip the table.
// traced alloc, free, realloc release, checked access and leak scan read the chunk
// table one entry per cycle over its single read port, unless a leak scan stalls.
// a leak scan stalls on a full result queue; a 2-entry event queue keeps taking events.
// rst_ni is asynchronous and active low; the chunk table itself is not cleared.
module heap_chunk_safety_checker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  hcsc_pkg::in_item_t  in_item_i,
  output logic                empty_o,
  input  logic                pop_i,
  output hcsc_pkg::out_item_t out_item_o
);

  logic                cmd_valid, cmd_ready, oq_full, oq_push;
  hcsc_pkg::cmd_t      cmd;
  hcsc_pkg::out_item_t oq_item;

  // event intake and classification
  hcsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // table sequencer
  hcsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .oq_full_i   (oq_full),
    .oq_push_o   (oq_push),
    .oq_item_o   (oq_item)
  );

  // result queue
  hcsc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .item_i  (oq_item),
    .full_o  (oq_full),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .item_o  (out_item_o)
  );

endmodule
